>>> sv/mmt_pkg.sv
// Package for the modifier mask tracker: action codes, sizes and the word types
// shared by the core, the output buffer and the top level.
// No dependencies.
package mmt_pkg;

    localparam int NumModifiers = 8;
    localparam int MaskWidth    = 8;
    localparam int CountWidth   = 8;
    localparam int WordWidth    = 16;
    localparam int ActionWidth  = 3;

    localparam logic [MaskWidth-1:0] ModMask =
        MaskWidth'((9'd1 << NumModifiers) - 9'd1);

    localparam logic [ActionWidth-1:0] ActAdd            = 3'd0;
    localparam logic [ActionWidth-1:0] ActDelete         = 3'd1;
    localparam logic [ActionWidth-1:0] ActSetDisguise    = 3'd2;
    localparam logic [ActionWidth-1:0] ActRemoveDisguise = 3'd3;
    localparam logic [ActionWidth-1:0] ActFreeze         = 3'd4;
    localparam logic [ActionWidth-1:0] ActUnfreeze       = 3'd5;

    typedef struct packed {
        logic [ActionWidth-1:0] action;
        logic [MaskWidth-1:0]   modifier_mask;
        logic [WordWidth-1:0]   disguise_word;
    } event_t;

    typedef struct packed {
        logic                 report_sent;
        logic [MaskWidth-1:0] frozen_mask;
        logic [MaskWidth-1:0] disguised_mask;
    } result_t;

endpackage

>>> sv/mmt_core.sv
// Tracker state and the single-pass update for one event word.
// Depends on mmt_pkg.
module mmt_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  mmt_pkg::event_t  evt,
    output mmt_pkg::result_t res
);

    logic [mmt_pkg::CountWidth-1:0] press_counts_reg  [mmt_pkg::NumModifiers];
    logic [mmt_pkg::CountWidth-1:0] press_counts_next [mmt_pkg::NumModifiers];
    logic [mmt_pkg::MaskWidth-1:0]  frozen_bits_reg,    frozen_bits_next;
    logic [mmt_pkg::MaskWidth-1:0]  disguised_bits_reg, disguised_bits_next;
    logic [mmt_pkg::CountWidth-1:0] disguise_count_reg, disguise_count_next;
    logic [mmt_pkg::CountWidth-1:0] freeze_count_reg,   freeze_count_next;
    logic [mmt_pkg::WordWidth-1:0]  current_disguise_reg, current_disguise_next;

    logic [mmt_pkg::MaskWidth-1:0] mask;
    logic [mmt_pkg::MaskWidth-1:0] held_bits;
    logic [mmt_pkg::MaskWidth-1:0] recomputed;
    logic                          unfrozen;
    logic                          report;

    assign mask     = evt.modifier_mask & mmt_pkg::ModMask;
    assign unfrozen = (freeze_count_reg == '0);

    always_comb begin
        held_bits = '0;
        for (int i = 0; i < mmt_pkg::NumModifiers; i++) begin
            held_bits[i] = (press_counts_reg[i] != '0);
        end
    end

    always_comb begin
        for (int i = 0; i < mmt_pkg::NumModifiers; i++) begin
            press_counts_next[i] = press_counts_reg[i];
        end
        frozen_bits_next      = frozen_bits_reg;
        disguise_count_next   = disguise_count_reg;
        freeze_count_next     = freeze_count_reg;
        current_disguise_next = current_disguise_reg;
        report                = 1'b0;

        unique case (evt.action)
            mmt_pkg::ActAdd: begin
                for (int i = 0; i < mmt_pkg::NumModifiers; i++) begin
                    if (mask[i]) begin
                        press_counts_next[i] = press_counts_reg[i] + 1'b1;
                    end
                end
                if (unfrozen) begin
                    frozen_bits_next = frozen_bits_reg | mask;
                    report           = 1'b1;
                end
            end
            mmt_pkg::ActDelete: begin
                for (int i = 0; i < mmt_pkg::NumModifiers; i++) begin
                    if (mask[i]) begin
                        press_counts_next[i] = press_counts_reg[i] - 1'b1;
                        if (press_counts_next[i] == '0 && unfrozen) begin
                            frozen_bits_next[i] = 1'b0;
                        end
                    end
                end
                report = unfrozen;
            end
            mmt_pkg::ActSetDisguise: begin
                // A different word starts its count afresh.
                if (current_disguise_reg != evt.disguise_word) begin
                    current_disguise_next = evt.disguise_word;
                    disguise_count_next   = mmt_pkg::CountWidth'(1);
                end else begin
                    disguise_count_next = disguise_count_reg + 1'b1;
                end
                report = 1'b1;
            end
            mmt_pkg::ActRemoveDisguise: begin
                if (current_disguise_reg == evt.disguise_word && disguise_count_reg != '0) begin
                    disguise_count_next = disguise_count_reg - 1'b1;
                    report = (disguise_count_reg == mmt_pkg::CountWidth'(1));
                end
            end
            mmt_pkg::ActFreeze: begin
                freeze_count_next = freeze_count_reg + 1'b1;
            end
            mmt_pkg::ActUnfreeze: begin
                freeze_count_next = freeze_count_reg - 1'b1;
                frozen_bits_next  = held_bits;
                report            = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        recomputed = frozen_bits_next;
        if (disguise_count_next != '0) begin
            recomputed = (recomputed & ~current_disguise_next[mmt_pkg::WordWidth-1:8])
                       | current_disguise_next[7:0];
        end
        disguised_bits_next = report ? recomputed : disguised_bits_reg;
    end

    assign res.report_sent    = report;
    assign res.frozen_mask    = frozen_bits_next;
    assign res.disguised_mask = disguised_bits_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mmt_pkg::NumModifiers; i++) begin
                press_counts_reg[i] <= '0;
            end
            frozen_bits_reg      <= '0;
            disguised_bits_reg   <= '0;
            disguise_count_reg   <= '0;
            freeze_count_reg     <= '0;
            current_disguise_reg <= '0;
        end else if (take) begin
            for (int i = 0; i < mmt_pkg::NumModifiers; i++) begin
                press_counts_reg[i] <= press_counts_next[i];
            end
            frozen_bits_reg      <= frozen_bits_next;
            disguised_bits_reg   <= disguised_bits_next;
            disguise_count_reg   <= disguise_count_next;
            freeze_count_reg     <= freeze_count_next;
            current_disguise_reg <= current_disguise_next;
        end
    end

`ifndef ASSERT_OFF
    // With no disguise outstanding the disguised set is the frozen set.
    a_plain_when_undisguised: assert property (@(posedge aclk) disable iff (!aresetn)
        disguise_count_reg == '0 |-> disguised_bits_reg == frozen_bits_reg)
        else $error("disguised set differs from frozen set without a disguise");

    a_freeze_holds_set: assert property (@(posedge aclk) disable iff (!aresetn)
        take && evt.action == mmt_pkg::ActFreeze |=> $stable(frozen_bits_reg))
        else $error("freeze changed the frozen set");

    a_unused_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (evt.action == 3'd6 || evt.action == 3'd7)
        |-> !report && frozen_bits_next == frozen_bits_reg)
        else $error("unused action had an effect");

    a_frozen_no_report: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !unfrozen && (evt.action == mmt_pkg::ActAdd || evt.action == mmt_pkg::ActDelete)
        |=> $stable(frozen_bits_reg) && $stable(disguised_bits_reg))
        else $error("add or delete moved the sets while frozen");
`endif

endmodule

>>> sv/mmt_out_buf.sv
// Result register with a skid stage, so that the ready seen by the core comes
// straight from a register. Depends on mmt_pkg.
module mmt_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mmt_pkg::result_t in_res,
    output logic             out_valid,
    input  logic             out_ready,
    output mmt_pkg::result_t out_res
);

    logic             main_valid_reg, skid_valid_reg;
    mmt_pkg::result_t main_res_reg,   skid_res_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end else if (in_valid && in_ready) begin
            skid_res_reg <= in_res;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds a word while the result register is empty");
`endif

endmodule

>>> sv/modifier_mask_tracker_unit.sv
// Modifier mask tracker: one result word for every event word, one event per clock while
// the output is not stalled. An event is registered on entry, the tracker state and result
// are computed in a single combinational pass, and the result is held in a result register
// with a skid stage. A result word goes from the input register to the result register, or
// through the skid stage when m_axis_tready holds the output; throughput is one event per cycle.
// Depends on mmt_pkg, mmt_core and mmt_out_buf.
module modifier_mask_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] modifier_mask, [23:8] disguise_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] report_sent, [8:1] frozen_mask,
                                        // [16:9] disguised_mask, [23:17] zero
);

    logic             in_valid_reg;
    mmt_pkg::event_t  in_evt_reg;
    logic             buf_ready;
    logic             take;
    mmt_pkg::result_t core_res;
    mmt_pkg::result_t out_res;

    assign take          = in_valid_reg && buf_ready;
    assign s_axis_tready = !in_valid_reg || buf_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_evt_reg.action        <= s_axis_tuser;
            in_evt_reg.modifier_mask <= s_axis_tdata[7:0];
            in_evt_reg.disguise_word <= s_axis_tdata[23:8];
        end
    end

    mmt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .evt     (in_evt_reg),
        .res     (core_res)
    );

    mmt_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (buf_ready),
        .in_res    (core_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.disguised_mask, out_res.frozen_mask,
                           out_res.report_sent};

endmodule
